FILE: rtl/kerned_text_line_width_defines.svh
// ----------------------------------------------------------------------------
// kerned_text_line_width_defines.svh
// Assertion macros used by the line width controller module.
// ----------------------------------------------------------------------------
`ifndef KERNED_TEXT_LINE_WIDTH_DEFINES_SVH
`define KERNED_TEXT_LINE_WIDTH_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted
`define KTLW_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is asserted
`define KTLW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ktlw_pkg.sv
// ----------------------------------------------------------------------------
// ktlw_pkg
// Types, codes and sizes shared by the text line width measurement block.
// ----------------------------------------------------------------------------
`default_nettype none

package ktlw_pkg;

  // Table and accumulator sizes
  localparam int GLYPH_DEPTH = 256;
  localparam int KERN_DEPTH  = 256;
  localparam int SUM_BITS    = 16;

  localparam logic [8:0] KERN_DEPTH_N = 9'(KERN_DEPTH);
  localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

  // Special character codes
  localparam logic [7:0] CHAR_NUL      = 8'h00;
  localparam logic [7:0] CHAR_NEWLINE  = 8'h0a;
  localparam logic [7:0] CTRL_SKIP_MAX = 8'h03;
  localparam logic [7:0] CTRL_DROP_MAX = 8'h06;

  // Input item actions
  localparam logic [1:0] ACT_TEXT  = 2'd0;
  localparam logic [1:0] ACT_GLYPH = 2'd1;
  localparam logic [1:0] ACT_KERN  = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_MIN_CHAR     = 3'd0;
  localparam logic [2:0] CFG_MAX_CHAR     = 3'd1;
  localparam logic [2:0] CFG_PROPORTIONAL = 3'd2;
  localparam logic [2:0] CFG_KERNED       = 3'd3;
  localparam logic [2:0] CFG_FIXED_WIDTH  = 3'd4;
  localparam logic [2:0] CFG_KERN_COUNT   = 3'd5;

  // One kerning table entry
  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic [8:0] value;
  } ktlw_kern_entry_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_BASE,
    ST_SCAN,
    ST_ADD,
    ST_LINE
  } ktlw_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic kinit;
    logic kadv;
    logic load_base;
    logic load_kern;
    logic add;
    logic commit;
  } ktlw_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_text;
    logic pending_valid;
    logic kern_go;
    logic kern_match;
    logic kern_last;
    logic line_ends;
    logic out_free;
  } ktlw_sts_t;

endpackage

`default_nettype wire

FILE: rtl/kerned_text_line_width.sv
// Table writes are taken in the idle state. A text byte with no pending character
// runs the idle, evaluate and line states; one that settles a pending character also
// runs base, a kerning scan when it applies (one entry at a time, up to 256, through
// the single read port of the kerning table), then add. A line result is registered
// as its ending byte commits in the line state, held while an earlier result waits.
// Synchronous active-low reset sets config defaults, clears line, FSM and out_valid.
// ----------------------------------------------------------------------------
// kerned_text_line_width
// Measures the pixel width of one text line from a stream of text bytes,
// with glyph width and kerning tables loaded through the same channel.
// ----------------------------------------------------------------------------
`default_nettype none

module kerned_text_line_width (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // input channel
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                in_action,
  input  wire logic [7:0]                in_text_byte,
  input  wire logic [7:0]                in_table_index,
  input  wire logic [7:0]                in_kern_first,
  input  wire logic [7:0]                in_kern_second,
  input  wire logic [8:0]                in_entry_value,
  // configuration write port
  input  wire logic                      cfg_we,
  input  wire logic [2:0]                cfg_index,
  input  wire logic [8:0]                cfg_data,
  // result channel
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [ktlw_pkg::SUM_BITS-1:0]  out_line_width,
  output logic                           out_saturated
);

  ktlw_pkg::ktlw_cmd_t cmd;
  ktlw_pkg::ktlw_sts_t sts;

  // sequencer
  ktlw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // tables, accumulator and output register
  ktlw_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_action      (in_action),
    .in_text_byte   (in_text_byte),
    .in_table_index (in_table_index),
    .in_kern_first  (in_kern_first),
    .in_kern_second (in_kern_second),
    .in_entry_value (in_entry_value),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_line_width (out_line_width),
    .out_saturated  (out_saturated)
  );

endmodule

`default_nettype wire

FILE: rtl/ktlw_datapath.sv
// ----------------------------------------------------------------------------
// ktlw_datapath
// Configuration registers, glyph and kerning tables, line state, running sum
// and the output register of the text line width block.
// ----------------------------------------------------------------------------
`default_nettype none

module ktlw_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input item fields
  input  wire logic [1:0]                    in_action,
  input  wire logic [7:0]                    in_text_byte,
  input  wire logic [7:0]                    in_table_index,
  input  wire logic [7:0]                    in_kern_first,
  input  wire logic [7:0]                    in_kern_second,
  input  wire logic [8:0]                    in_entry_value,
  // configuration write port
  input  wire logic                          cfg_we,
  input  wire logic [2:0]                    cfg_index,
  input  wire logic [8:0]                    cfg_data,
  // controller interface
  input  wire ktlw_pkg::ktlw_cmd_t           cmd,
  output ktlw_pkg::ktlw_sts_t                sts,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [ktlw_pkg::SUM_BITS-1:0]      out_line_width,
  output logic                               out_saturated
);

  // configuration registers
  logic [7:0] min_char_r;
  logic [7:0] max_char_r;
  logic       proportional_r;
  logic       kerned_r;
  logic [8:0] fixed_width_r;
  logic [8:0] kern_count_r;

  // tables
  logic [8:0]                  glyph_mem [ktlw_pkg::GLYPH_DEPTH];
  ktlw_pkg::ktlw_kern_entry_t  kern_mem  [ktlw_pkg::KERN_DEPTH];
  logic [8:0]                  glyph_rd_r;
  ktlw_pkg::ktlw_kern_entry_t  kern_rd_r;

  // line state
  logic                            pending_valid_r;
  logic [7:0]                      pending_code_r;
  logic                            skip_r;
  logic [ktlw_pkg::SUM_BITS-1:0]   sum_r;
  logic                            ovf_r;
  logic [7:0]                      byte_r;
  logic [8:0]                      adv_r;
  logic [7:0]                      kidx_r;

  // output register
  logic                            out_valid_r;
  logic [ktlw_pkg::SUM_BITS-1:0]   out_width_r;
  logic                            out_sat_r;

  // derived values
  logic                          pend_in_font;
  logic                          byte_in_font;
  logic [7:0]                    glyph_addr;
  logic [7:0]                    next_glyph;
  logic [7:0]                    kern_addr;
  logic [8:0]                    kern_n;
  logic [8:0]                    base_adv;
  logic [ktlw_pkg::SUM_BITS:0]   sum_ext;
  logic                          line_ends;
  logic                          write_acc;

  // font membership and glyph indexes
  assign pend_in_font = (pending_code_r >= min_char_r) && (pending_code_r <= max_char_r);
  assign byte_in_font = (byte_r >= min_char_r) && (byte_r <= max_char_r);
  assign glyph_addr   = pending_code_r - min_char_r;
  assign next_glyph   = byte_r - min_char_r;

  // clamp the searched kerning entry count to the table depth
  assign kern_n = (kern_count_r > ktlw_pkg::KERN_DEPTH_N) ? ktlw_pkg::KERN_DEPTH_N
                                                          : kern_count_r;

  // hold the kerning read address unless the scan starts or advances
  always_comb begin
    if (cmd.kinit) begin
      kern_addr = 8'd0;
    end else if (cmd.kadv) begin
      kern_addr = kidx_r + 8'd1;
    end else begin
      kern_addr = kidx_r;
    end
  end

  // advance before kerning
  always_comb begin
    if (!pend_in_font) begin
      base_adv = proportional_r ? {1'b0, fixed_width_r[8:1]} : fixed_width_r;
    end else begin
      base_adv = proportional_r ? glyph_rd_r : fixed_width_r;
    end
  end

  // line end: a skipped byte ends the line only when it is NUL
  assign line_ends = skip_r ? (byte_r == ktlw_pkg::CHAR_NUL)
                            : ((byte_r == ktlw_pkg::CHAR_NUL) ||
                               (byte_r == ktlw_pkg::CHAR_NEWLINE));

  assign sum_ext   = {1'b0, sum_r} + (ktlw_pkg::SUM_BITS+1)'(adv_r);
  assign write_acc = cmd.accept;

  // status toward the controller
  always_comb begin
    sts.is_text       = (in_action == ktlw_pkg::ACT_TEXT);
    sts.pending_valid = pending_valid_r;
    sts.kern_go       = pend_in_font && kerned_r && byte_in_font &&
                        (byte_r != ktlw_pkg::CHAR_NUL) &&
                        (byte_r != ktlw_pkg::CHAR_NEWLINE) && (kern_n != 9'd0);
    sts.kern_match    = (kern_rd_r.first == glyph_addr) && (kern_rd_r.second == next_glyph);
    sts.kern_last     = ((9'(kidx_r) + 9'd1) == kern_n);
    sts.line_ends     = line_ends;
    sts.out_free      = !out_valid_r || out_ready;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_char_r     <= 8'd32;
      max_char_r     <= 8'd127;
      proportional_r <= 1'b0;
      kerned_r       <= 1'b0;
      fixed_width_r  <= 9'd8;
      kern_count_r   <= 9'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ktlw_pkg::CFG_MIN_CHAR:     min_char_r     <= cfg_data[7:0];
        ktlw_pkg::CFG_MAX_CHAR:     max_char_r     <= cfg_data[7:0];
        ktlw_pkg::CFG_PROPORTIONAL: proportional_r <= cfg_data[0];
        ktlw_pkg::CFG_KERNED:       kerned_r       <= cfg_data[0];
        ktlw_pkg::CFG_FIXED_WIDTH:  fixed_width_r  <= cfg_data;
        ktlw_pkg::CFG_KERN_COUNT:   kern_count_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // glyph width table: write on transfer, read every cycle
  always_ff @(posedge clk) begin
    if (write_acc && (in_action == ktlw_pkg::ACT_GLYPH)) begin
      glyph_mem[in_table_index] <= in_entry_value;
    end
    glyph_rd_r <= glyph_mem[glyph_addr];
  end

  // kerning table: write on transfer, read at the scan address
  always_ff @(posedge clk) begin
    if (write_acc && (in_action == ktlw_pkg::ACT_KERN)) begin
      kern_mem[in_table_index] <= '{first: in_kern_first, second: in_kern_second,
                                    value: in_entry_value};
    end
    kern_rd_r <= kern_mem[kern_addr];
  end

  // capture byte, scan index and advance
  always_ff @(posedge clk) begin
    if (write_acc && (in_action == ktlw_pkg::ACT_TEXT)) begin
      byte_r <= in_text_byte;
    end
    if (cmd.kinit) begin
      kidx_r <= 8'd0;
    end else if (cmd.kadv) begin
      kidx_r <= kidx_r + 8'd1;
    end
    if (cmd.load_base) begin
      adv_r <= base_adv;
    end else if (cmd.load_kern) begin
      adv_r <= kern_rd_r.value;
    end
  end

  // line state: accumulate advances, then update pending and skip
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_valid_r <= 1'b0;
      pending_code_r  <= 8'd0;
      skip_r          <= 1'b0;
      sum_r           <= '0;
      ovf_r           <= 1'b0;
    end else if (cmd.add) begin
      if (sum_ext[ktlw_pkg::SUM_BITS]) begin
        sum_r <= ktlw_pkg::SUM_MAX;
        ovf_r <= 1'b1;
      end else begin
        sum_r <= sum_ext[ktlw_pkg::SUM_BITS-1:0];
      end
    end else if (cmd.commit) begin
      priority if (line_ends) begin
        pending_valid_r <= 1'b0;
        pending_code_r  <= 8'd0;
        skip_r          <= 1'b0;
        sum_r           <= '0;
        ovf_r           <= 1'b0;
      end else if (skip_r) begin
        skip_r          <= 1'b0;
        pending_valid_r <= 1'b0;
      end else if (byte_r <= ktlw_pkg::CTRL_DROP_MAX) begin
        skip_r          <= (byte_r <= ktlw_pkg::CTRL_SKIP_MAX);
        pending_valid_r <= 1'b0;
      end else begin
        pending_valid_r <= 1'b1;
        pending_code_r  <= byte_r;
      end
    end
  end

  // output register: load on line end, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit && line_ends) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && line_ends) begin
      out_width_r <= sum_r;
      out_sat_r   <= ovf_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_line_width = out_width_r;
  assign out_saturated  = out_sat_r;

endmodule

`default_nettype wire

FILE: rtl/ktlw_ctrl.sv
// ----------------------------------------------------------------------------
// ktlw_ctrl
// Sequencer for one text byte: settle the pending advance, search the
// kerning table, accumulate and update the line state.
// ----------------------------------------------------------------------------
`default_nettype none

`include "kerned_text_line_width_defines.svh"

module ktlw_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire ktlw_pkg::ktlw_sts_t  sts,
  output ktlw_pkg::ktlw_cmd_t       cmd
);

  ktlw_pkg::ktlw_state_t state_r;
  ktlw_pkg::ktlw_state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ktlw_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ktlw_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.is_text) begin
            state_nxt = ktlw_pkg::ST_EVAL;
          end
        end
      end
      ktlw_pkg::ST_EVAL: begin
        cmd.kinit = 1'b1;
        state_nxt = sts.pending_valid ? ktlw_pkg::ST_BASE : ktlw_pkg::ST_LINE;
      end
      ktlw_pkg::ST_BASE: begin
        cmd.load_base = 1'b1;
        state_nxt     = sts.kern_go ? ktlw_pkg::ST_SCAN : ktlw_pkg::ST_ADD;
      end
      ktlw_pkg::ST_SCAN: begin
        priority if (sts.kern_match) begin
          cmd.load_kern = 1'b1;
          state_nxt     = ktlw_pkg::ST_ADD;
        end else if (sts.kern_last) begin
          state_nxt = ktlw_pkg::ST_ADD;
        end else begin
          cmd.kadv = 1'b1;
        end
      end
      ktlw_pkg::ST_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = ktlw_pkg::ST_LINE;
      end
      ktlw_pkg::ST_LINE: begin
        if (!sts.line_ends || sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ktlw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ktlw_pkg::ST_IDLE;
      end
    endcase
  end

  // checks
  `KTLW_ASSERT_NEXT(a_text_starts, in_valid && in_ready && sts.is_text,
                    state_r == ktlw_pkg::ST_EVAL, "accepted text byte did not start work")
  `KTLW_ASSERT_NEXT(a_match_adds, state_r == ktlw_pkg::ST_SCAN && sts.kern_match,
                    state_r == ktlw_pkg::ST_ADD, "kerning match did not end the search")
  `KTLW_ASSERT_NEXT(a_no_pending, state_r == ktlw_pkg::ST_EVAL && !sts.pending_valid,
                    state_r == ktlw_pkg::ST_LINE, "byte without pending advance added one")
  `KTLW_ASSERT_IMPL(a_commit_free, cmd.commit && sts.line_ends, sts.out_free,
                    "line result overwrote a waiting result")

endmodule

`default_nettype wire
